@@ design/tbswe_pkg.sv @@
// shared types and constants for the two-band stereo width enhancer
`timescale 1ns / 1ps
package tbswe_pkg;

  // fixed internal widths (filter state is always 32 bit)
  localparam int ACC_W     = 32;  // lowpass state
  localparam int HI_W      = 33;  // high band sample
  localparam int BAND_W    = 34;  // mid*2 and side of one band
  localparam int T_W       = 38;  // widened band before norm
  localparam int MA_W      = 38;  // multiplier operand a, signed
  localparam int MB_W      = 18;  // multiplier operand b, signed
  localparam int PROD_W    = MA_W + MB_W;
  localparam int SUM_W     = 52;  // lowpass product sum
  localparam int Y_W       = 40;  // per-channel band sum
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_W  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_N  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_W = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_N = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] POLE_RST   = 16'd61384;
  localparam logic [CFG_W-1:0] WIDTH_RST  = 16'd16384;
  localparam logic [CFG_W-1:0] NORM_RST   = 16'd32768;

  typedef struct packed {
    logic [CFG_W-1:0] pole;
    logic [CFG_W-1:0] low_w;
    logic [CFG_W-1:0] low_n;
    logic [CFG_W-1:0] high_w;
    logic [CFG_W-1:0] high_n;
  } cfg_t;

  // operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_GAIN_LS,
    MUL_POLE_ACCL,
    MUL_GAIN_RS,
    MUL_POLE_ACCR,
    MUL_SIDE_LW,
    MUL_SIDE_HW,
    MUL_TA_LN,
    MUL_TB_LN,
    MUL_TA_HN,
    MUL_TB_HN
  } mul_sel_e;

  typedef enum logic [1:0] {
    LP_NONE,
    LP_LOAD,
    LP_FIN_L,
    LP_FIN_R
  } lp_op_e;

  typedef enum logic [1:0] {
    BAND_NONE,
    BAND_LO,
    BAND_HI
  } band_op_e;

  typedef enum logic [2:0] {
    Y_NONE,
    Y_LOAD_L,
    Y_LOAD_R,
    Y_ADD_L,
    Y_ADD_R
  } y_op_e;

  typedef struct packed {
    logic     in_load;
    mul_sel_e mul_sel;
    lp_op_e   lp_op;
    band_op_e band_op;
    logic     t_split;
    y_op_e    y_op;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/two_band_stereo_width_enhancer.sv @@
// top level of the two-band mid/side stereo width enhancer
`timescale 1ns / 1ps
// usage
//   input channel: in_valid_i / in_ready_o carry one stereo pair (left_in_i,
//   right_in_i, signed Q1.23 at the default width). one request in, one
//   request out, in order.
//   output channel: out_valid_o / out_ready_i carry the enhanced pair; the
//   result sits in an output register, so the block takes the next input
//   request while a finished result still waits to be taken.
//   config: cfg_we_i writes cfg_data_i to register cfg_idx_i (pole, low
//   width, low norm, high width, high norm); other indexes are ignored.
//   write only while the block is idle.
// timing
//   one shared multiplier does all ten products of an item, one at a time;
//   an item runs through every step of the sequencer, so the block takes a
//   new input only once the last one has moved into the output register
//   and the sequencer is back in idle.
//   if the receiver stalls, the finished item waits in the last step until
//   the output register frees up; input is not taken meanwhile.
// reset
//   rst_ni clears both lowpass states, loads default registers and empties
//   the output register; the block is ready as soon as reset is released.
module two_band_stereo_width_enhancer import tbswe_pkg::*; #(
  parameter int SAMPLE_BITS   = 24,
  parameter int ACC_FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  // output requests
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  // register writes
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  cfg_t     cfg_q;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register file: five 16-bit gains, reset to unity widening
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pole   <= POLE_RST;
      cfg_q.low_w  <= WIDTH_RST;
      cfg_q.low_n  <= NORM_RST;
      cfg_q.high_w <= WIDTH_RST;
      cfg_q.high_n <= NORM_RST;
    end else if (cfg_we_i) begin
      // indexes past the last register fall through untouched
      if (cfg_idx_i == REG_POLE) begin
        cfg_q.pole <= cfg_data_i;
      end
      if (cfg_idx_i == REG_LOW_W) begin
        cfg_q.low_w <= cfg_data_i;
      end
      if (cfg_idx_i == REG_LOW_N) begin
        cfg_q.low_n <= cfg_data_i;
      end
      if (cfg_idx_i == REG_HIGH_W) begin
        cfg_q.high_w <= cfg_data_i;
      end
      if (cfg_idx_i == REG_HIGH_N) begin
        cfg_q.high_n <= cfg_data_i;
      end
    end
  end

  // sequencer: steps the datapath through filter, low band, high band
  tbswe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: shared multiplier, lowpass state and output register
  tbswe_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .ACC_FRAC_BITS (ACC_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_i       (cfg_q),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in progress");
`endif

endmodule

@@ design/tbswe_ctrl.sv @@
// datapath sequencer: one-hot state machine, one step per cycle unless stalled
`timescale 1ns / 1ps
module tbswe_ctrl import tbswe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_LPL_A    = 18'h00002,
    S_LPL_B    = 18'h00004,
    S_LPR_A    = 18'h00008,
    S_LPR_B    = 18'h00010,
    S_LP_END   = 18'h00020,
    S_LO_BAND  = 18'h00040,
    S_LO_SIDE  = 18'h00080,
    S_LO_SPLIT = 18'h00100,
    S_LO_NL    = 18'h00200,
    S_LO_NR    = 18'h00400,
    S_HI_BAND  = 18'h00800,
    S_HI_SIDE  = 18'h01000,
    S_HI_SPLIT = 18'h02000,
    S_HI_NL    = 18'h04000,
    S_HI_NR    = 18'h08000,
    S_HI_END   = 18'h10000,
    S_DONE     = 18'h20000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // a product issued in one state is consumed by the op of the next state
  always_comb begin
    state_d        = state_q;
    cmd_o.in_load  = 1'b0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.lp_op    = LP_NONE;
    cmd_o.band_op  = BAND_NONE;
    cmd_o.t_split  = 1'b0;
    cmd_o.y_op     = Y_NONE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_LPL_A;
        end
      end
      S_LPL_A: begin
        cmd_o.mul_sel = MUL_GAIN_LS;
        state_d       = S_LPL_B;
      end
      S_LPL_B: begin
        cmd_o.mul_sel = MUL_POLE_ACCL;
        cmd_o.lp_op   = LP_LOAD;
        state_d       = S_LPR_A;
      end
      S_LPR_A: begin
        cmd_o.mul_sel = MUL_GAIN_RS;
        cmd_o.lp_op   = LP_FIN_L;
        state_d       = S_LPR_B;
      end
      S_LPR_B: begin
        cmd_o.mul_sel = MUL_POLE_ACCR;
        cmd_o.lp_op   = LP_LOAD;
        state_d       = S_LP_END;
      end
      S_LP_END: begin
        cmd_o.lp_op = LP_FIN_R;
        state_d     = S_LO_BAND;
      end
      S_LO_BAND: begin
        cmd_o.band_op = BAND_LO;
        state_d       = S_LO_SIDE;
      end
      S_LO_SIDE: begin
        cmd_o.mul_sel = MUL_SIDE_LW;
        state_d       = S_LO_SPLIT;
      end
      S_LO_SPLIT: begin
        cmd_o.t_split = 1'b1;
        state_d       = S_LO_NL;
      end
      S_LO_NL: begin
        cmd_o.mul_sel = MUL_TA_LN;
        state_d       = S_LO_NR;
      end
      S_LO_NR: begin
        cmd_o.mul_sel = MUL_TB_LN;
        cmd_o.y_op    = Y_LOAD_L;
        state_d       = S_HI_BAND;
      end
      S_HI_BAND: begin
        cmd_o.y_op    = Y_LOAD_R;
        cmd_o.band_op = BAND_HI;
        state_d       = S_HI_SIDE;
      end
      S_HI_SIDE: begin
        cmd_o.mul_sel = MUL_SIDE_HW;
        state_d       = S_HI_SPLIT;
      end
      S_HI_SPLIT: begin
        cmd_o.t_split = 1'b1;
        state_d       = S_HI_NL;
      end
      S_HI_NL: begin
        cmd_o.mul_sel = MUL_TA_HN;
        state_d       = S_HI_NR;
      end
      S_HI_NR: begin
        cmd_o.mul_sel = MUL_TB_HN;
        cmd_o.y_op    = Y_ADD_L;
        state_d       = S_HI_END;
      end
      S_HI_END: begin
        cmd_o.y_op = Y_ADD_R;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_LPL_A))
    else $error("accepted request did not start the filter sequence");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !stat_i.out_free) |=> (state_q == S_DONE))
    else $error("result left the done state while the output was occupied");
`endif

endmodule

@@ design/tbswe_dp.sv @@
// enhancer datapath: shared multiplier, filter state, band registers, output stage
`timescale 1ns / 1ps
module tbswe_dp import tbswe_pkg::*; #(
  parameter int SAMPLE_BITS   = 24,
  parameter int ACC_FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_stat_t                      stat_o,
  input  cfg_t                          cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);

  localparam int EXT_W  = SAMPLE_BITS + ACC_FRAC_BITS;
  localparam int CMP_W  = (EXT_W > ACC_W) ? EXT_W : ACC_W + 1;
  localparam int HALF_SH = (ACC_FRAC_BITS > 0) ? ACC_FRAC_BITS - 1 : 0;

  localparam logic signed [CMP_W-1:0] IN_ONE = 1;
  localparam logic signed [CMP_W-1:0] IN_MAX = (IN_ONE <<< (ACC_W - 1)) - IN_ONE;
  localparam logic signed [CMP_W-1:0] IN_MIN = -IN_MAX - IN_ONE;

  localparam logic signed [SUM_W-1:0] LP_ONE  = 1;
  localparam logic signed [SUM_W-1:0] LP_HALF = LP_ONE <<< 15;
  localparam logic signed [SUM_W-1:0] LP_MAX  = (LP_ONE <<< (ACC_W - 1)) - LP_ONE;
  localparam logic signed [SUM_W-1:0] LP_MIN  = -LP_MAX - LP_ONE;

  localparam logic signed [Y_W:0] Y_ONE  = 1;
  localparam logic signed [Y_W:0] Y_HALF = (ACC_FRAC_BITS > 0) ? (Y_ONE <<< HALF_SH) : '0;
  localparam logic signed [Y_W:0] Y_MAX  = (Y_ONE <<< (SAMPLE_BITS - 1)) - Y_ONE;
  localparam logic signed [Y_W:0] Y_MIN  = -Y_MAX - Y_ONE;

  localparam logic signed [PROD_W-1:0] N_HALF = PROD_W'(16384);
  localparam logic signed [52:0]       T_HALF = 53'sd8192;

  // sample to filter scale, saturated to the state width
  function automatic logic signed [ACC_W-1:0] in_scale(logic signed [SAMPLE_BITS-1:0] s);
    logic signed [CMP_W-1:0] e;
    e = CMP_W'(s) <<< ACC_FRAC_BITS;
    if (e > IN_MAX) begin
      e = IN_MAX;
    end else if (e < IN_MIN) begin
      e = IN_MIN;
    end
    return e[ACC_W-1:0];
  endfunction

  // filter sum back to state scale, rounded and saturated
  function automatic logic signed [ACC_W-1:0] lp_fin(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + LP_HALF) >>> 16;
    if (r > LP_MAX) begin
      r = LP_MAX;
    end else if (r < LP_MIN) begin
      r = LP_MIN;
    end
    return r[ACC_W-1:0];
  endfunction

  // band sum back to sample scale, rounded and saturated
  function automatic logic signed [SAMPLE_BITS-1:0] y_fin(logic signed [Y_W-1:0] y);
    logic signed [Y_W:0] r;
    r = ((Y_W+1)'(y) + Y_HALF) >>> ACC_FRAC_BITS;
    if (r > Y_MAX) begin
      r = Y_MAX;
    end else if (r < Y_MIN) begin
      r = Y_MIN;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  logic signed [ACC_W-1:0]  ls_q, rs_q;
  logic signed [ACC_W-1:0]  accl_q, accl_d, accr_q, accr_d;
  logic signed [HI_W-1:0]   hl_q, hr_q;
  logic signed [BAND_W-1:0] m_q, s_q;
  logic signed [T_W-1:0]    ta_q, tb_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [Y_W-1:0]    yl_q, yr_q;
  logic signed [SAMPLE_BITS-1:0] lout_q, rout_q;
  logic                     out_valid_q;

  logic [16:0]              gain;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  lp_sum;
  logic signed [52:0]       mid_sc, ws;
  logic signed [T_W-1:0]    ta_d, tb_d;
  logic signed [Y_W-1:0]    n_rnd;

  assign gain = 17'd65536 - {1'b0, cfg_i.pole};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_GAIN_LS: begin
        mul_a = MA_W'(ls_q);
        mul_b = signed'({1'b0, gain});
      end
      MUL_POLE_ACCL: begin
        mul_a = MA_W'(accl_q);
        mul_b = signed'({2'b00, cfg_i.pole});
      end
      MUL_GAIN_RS: begin
        mul_a = MA_W'(rs_q);
        mul_b = signed'({1'b0, gain});
      end
      MUL_POLE_ACCR: begin
        mul_a = MA_W'(accr_q);
        mul_b = signed'({2'b00, cfg_i.pole});
      end
      MUL_SIDE_LW: begin
        mul_a = MA_W'(s_q);
        mul_b = signed'({2'b00, cfg_i.low_w});
      end
      MUL_SIDE_HW: begin
        mul_a = MA_W'(s_q);
        mul_b = signed'({2'b00, cfg_i.high_w});
      end
      MUL_TA_LN: begin
        mul_a = ta_q;
        mul_b = signed'({2'b00, cfg_i.low_n});
      end
      MUL_TB_LN: begin
        mul_a = tb_q;
        mul_b = signed'({2'b00, cfg_i.low_n});
      end
      MUL_TA_HN: begin
        mul_a = ta_q;
        mul_b = signed'({2'b00, cfg_i.high_n});
      end
      MUL_TB_HN: begin
        mul_a = tb_q;
        mul_b = signed'({2'b00, cfg_i.high_n});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // second filter product joins the first, then round and saturate
  assign lp_sum = sum_q + signed'(prod_q[SUM_W-1:0]);

  // mid*2 at Q13, i.e. mid at Q14 scale, plus and minus the scaled side
  assign mid_sc = 53'(m_q) <<< 13;
  assign ws     = signed'(prod_q[52:0]);
  assign ta_d   = T_W'((mid_sc + ws + T_HALF) >>> 14);
  assign tb_d   = T_W'((mid_sc - ws + T_HALF) >>> 14);

  assign n_rnd  = Y_W'((prod_q + N_HALF) >>> 15);

  always_comb begin
    accl_d = accl_q;
    accr_d = accr_q;
    if (cmd_i.lp_op == LP_FIN_L) begin
      accl_d = lp_fin(lp_sum);
    end
    if (cmd_i.lp_op == LP_FIN_R) begin
      accr_d = lp_fin(lp_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accl_q      <= '0;
      accr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      accl_q <= accl_d;
      accr_q <= accr_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.in_load) begin
      ls_q <= in_scale(left_in_i);
      rs_q <= in_scale(right_in_i);
    end
    if (cmd_i.lp_op == LP_LOAD) begin
      sum_q <= signed'(prod_q[SUM_W-1:0]);
    end
    unique case (cmd_i.band_op)
      BAND_NONE: begin
      end
      BAND_LO: begin
        m_q  <= BAND_W'(accl_q) + BAND_W'(accr_q);
        s_q  <= BAND_W'(accl_q) - BAND_W'(accr_q);
        hl_q <= HI_W'(ls_q) - HI_W'(accl_q);
        hr_q <= HI_W'(rs_q) - HI_W'(accr_q);
      end
      BAND_HI: begin
        m_q <= BAND_W'(hl_q) + BAND_W'(hr_q);
        s_q <= BAND_W'(hl_q) - BAND_W'(hr_q);
      end
      default: begin
      end
    endcase
    if (cmd_i.t_split) begin
      ta_q <= ta_d;
      tb_q <= tb_d;
    end
    unique case (cmd_i.y_op)
      Y_NONE: begin
      end
      Y_LOAD_L: yl_q <= n_rnd;
      Y_LOAD_R: yr_q <= n_rnd;
      Y_ADD_L:  yl_q <= yl_q + n_rnd;
      Y_ADD_R:  yr_q <= yr_q + n_rnd;
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      lout_q <= y_fin(yl_q);
      rout_q <= y_fin(yr_q);
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign left_out_o      = lout_q;
  assign right_out_o     = rout_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while a result was still pending");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the two-band stereo width enhancer
`timescale 1ns / 1ps
module testbench;
  import tbswe_pkg::*;

  localparam int SAMPLE_W     = 24;
  localparam int FRAC_BITS    = 8;
  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 8;
  // give each request room to finish before a register write
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_COUNT     = 6;
  localparam int PHASE_ITEMS     = 225;
  localparam int REPORT_LIMIT    = 10;
  // timeout in ns; reaching it fails the test
  localparam longint TIMEOUT_NS  = 64'd6_000_000;

  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam logic signed [SAMPLE_W-1:0] PAIR_MAX = SAMPLE_W'(SAMPLE_MAX);
  localparam logic signed [SAMPLE_W-1:0] PAIR_MIN = SAMPLE_W'(SAMPLE_MIN);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_HIGH_N + 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
  } stereo_pair_t;

  // shapes of stimulus within one burst
  typedef enum int {
    SIG_FULL,   // uncorrelated full-scale noise
    SIG_SMALL,  // low-level noise around zero
    SIG_DC,     // steady level plus a little noise, charges the lowpass
    SIG_MONO,   // left equals right, side is zero
    SIG_ANTI,   // right is minus left, mid is zero
    SIG_RAIL    // only rails, zero and minus one
  } sig_kind_e;

  typedef enum int {
    RX_ALWAYS,
    RX_PATTERN,
    RX_RANDOM
  } rx_mode_e;

  // bit-accurate model of the widener: lowpass split, mid/side per band, sum
  class stereo_widen_model;
    logic [CFG_W-1:0] pole, low_w, low_n, high_w, high_n;
    longint           lp_left, lp_right;
    stereo_pair_t     pending_pairs[$];
    int               mismatches;
    int               results;

    function new();
      pole     = POLE_RST;
      low_w    = WIDTH_RST;
      low_n    = NORM_RST;
      high_w   = WIDTH_RST;
      high_n   = NORM_RST;
      lp_left  = 0;
      lp_right = 0;
      mismatches = 0;
      results    = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
        REG_POLE:   pole   = data;
        REG_LOW_W:  low_w  = data;
        REG_LOW_N:  low_n  = data;
        REG_HIGH_W: high_w = data;
        REG_HIGH_N: high_n = data;
        default: ;  // unused indexes change nothing
      endcase
    endfunction

    // divide by 2^s, rounding half up
    function longint shift_round(input longint v, input int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint saturate(input longint v, input int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function longint lowpass(input longint s, input longint acc);
      longint x;
      x = longint'(pole);
      return saturate(shift_round((65536 - x) * s + x * acc, 16), 32);
    endfunction

    function void widen(input longint l, input longint r, input logic [CFG_W-1:0] w,
                        input logic [CFG_W-1:0] n, output longint ol, output longint orr);
      longint mid2, side_w, a, b;
      mid2   = l + r;
      side_w = (l - r) * longint'(w);
      a      = shift_round(mid2 * 8192 + side_w, 14);
      b      = shift_round(mid2 * 8192 - side_w, 14);
      ol     = shift_round(a * longint'(n), 15);
      orr    = shift_round(b * longint'(n), 15);
    endfunction

    function void note_request(input logic signed [SAMPLE_W-1:0] l_in,
                               input logic signed [SAMPLE_W-1:0] r_in);
      longint       ls, rs, lo_l, lo_r, hi_l, hi_r;
      stereo_pair_t want;
      ls = saturate(longint'(l_in) * (longint'(1) << FRAC_BITS), 32);
      rs = saturate(longint'(r_in) * (longint'(1) << FRAC_BITS), 32);
      lp_left  = lowpass(ls, lp_left);
      lp_right = lowpass(rs, lp_right);
      widen(lp_left, lp_right, low_w, low_n, lo_l, lo_r);
      widen(ls - lp_left, rs - lp_right, high_w, high_n, hi_l, hi_r);
      want.l = SAMPLE_W'(saturate(shift_round(lo_l + hi_l, FRAC_BITS), SAMPLE_W));
      want.r = SAMPLE_W'(saturate(shift_round(lo_r + hi_r, FRAC_BITS), SAMPLE_W));
      pending_pairs.push_back(want);
    endfunction

    function void check_result(input logic signed [SAMPLE_W-1:0] l_got,
                               input logic signed [SAMPLE_W-1:0] r_got);
      stereo_pair_t want;
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("output with no input pending: left %0d right %0d", l_got, r_got);
        return;
      end
      want = pending_pairs.pop_front();
      if (want.l !== l_got || want.r !== r_got) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: left exp %0d got %0d, right exp %0d got %0d", results,
                   $signed(want.l), l_got, $signed(want.r), r_got);
      end
      results++;
    endfunction

    function int pending();
      return pending_pairs.size();
    endfunction

    function bit failed();
      return mismatches != 0 || pending_pairs.size() != 0;
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic signed [SAMPLE_W-1:0]  left_in_i   = '0;
  logic signed [SAMPLE_W-1:0]  right_in_i  = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0]  left_out_o;
  logic signed [SAMPLE_W-1:0]  right_out_o;
  logic                        cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i   = '0;
  logic [CFG_W-1:0]            cfg_data_i  = '0;

  stereo_widen_model enhancer_model = new();

  // receiver behavior, set by the stimulus between phases
  rx_mode_e   rx_mode       = RX_ALWAYS;
  logic [15:0] stall_pattern = 16'hFFFF;
  bit         hold_off      = 1'b0;

  // steady levels for dc bursts
  longint dc_left, dc_right;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  two_band_stereo_width_enhancer #(
    .SAMPLE_BITS  (SAMPLE_W),
    .ACC_FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .left_in_i  (left_in_i),
    .right_in_i (right_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .left_out_o (left_out_o),
    .right_out_o(right_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // both handshakes sampled at the edge, before any nonblocking update lands
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      enhancer_model.note_request(left_in_i, right_in_i);
    if (rst_ni && out_valid_o && out_ready_i)
      enhancer_model.check_result(left_out_o, right_out_o);
  end

  // receiver: steady, patterned or random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        // the sender keeps offering, so the block fills and drops in_ready
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_ready_i <= 1'b1;
          RX_PATTERN: begin
            out_ready_i   <= stall_pattern[0];
            stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
          end
          default:    out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // hold one request until it is taken; returns in the step of acceptance
  task automatic offer(input logic signed [SAMPLE_W-1:0] l, input logic signed [SAMPLE_W-1:0] r);
    in_valid_i <= 1'b1;
    left_in_i  <= l;
    right_in_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending and wait until every result is back and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (enhancer_model.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all five registers, then one write to an unused index
  task automatic set_config(input logic [CFG_W-1:0] pole, input logic [CFG_W-1:0] lw,
                            input logic [CFG_W-1:0] ln, input logic [CFG_W-1:0] hw,
                            input logic [CFG_W-1:0] hn);
    logic [CFG_IDX_W-1:0] idxs [5];
    logic [CFG_W-1:0]     vals [5];
    logic [CFG_IDX_W-1:0] stray_idx;
    logic [CFG_W-1:0]     stray_data;
    idxs = '{REG_POLE, REG_LOW_W, REG_LOW_N, REG_HIGH_W, REG_HIGH_N};
    vals = '{pole, lw, ln, hw, hn};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idxs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      enhancer_model.write_reg(idxs[i], vals[i]);
    end
    stray_idx  = CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1));
    stray_data = CFG_W'($urandom);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= stray_idx;
    cfg_data_i <= stray_data;
    @(posedge clk_i);
    enhancer_model.write_reg(stray_idx, stray_data);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_gain(input logic [CFG_W-1:0] unity);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return unity;
      2:       return 16'd32768;
      3:       return '1;  // beyond the documented range, drives saturation
      4:       return CFG_W'($urandom_range(0, 32768));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_pole();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return POLE_RST;
      2:       return '1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  function automatic longint rail_value();
    case ($urandom_range(0, 3))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic void make_pair(input sig_kind_e kind,
                                    output logic signed [SAMPLE_W-1:0] l,
                                    output logic signed [SAMPLE_W-1:0] r);
    longint neg;
    case (kind)
      SIG_SMALL: begin
        l = SAMPLE_W'(longint'($urandom_range(0, 8191)) - 4096);
        r = SAMPLE_W'(longint'($urandom_range(0, 8191)) - 4096);
      end
      SIG_DC: begin
        l = SAMPLE_W'(dc_left + longint'($urandom_range(0, 511)) - 256);
        r = SAMPLE_W'(dc_right + longint'($urandom_range(0, 511)) - 256);
      end
      SIG_MONO: begin
        l = SAMPLE_W'($urandom);
        r = l;
      end
      SIG_ANTI: begin
        l   = SAMPLE_W'($urandom);
        neg = -longint'(l);
        // negating the most negative sample clips to the top rail
        r   = SAMPLE_W'((neg > SAMPLE_MAX) ? SAMPLE_MAX : neg);
      end
      SIG_RAIL: begin
        l = SAMPLE_W'(rail_value());
        r = SAMPLE_W'(rail_value());
      end
      default: begin
        l = SAMPLE_W'($urandom);
        r = SAMPLE_W'($urandom);
      end
    endcase
  endfunction

  // bursts of one signal shape, optionally separated by idle gaps
  task automatic run_phase(input int count, input bit gaps);
    int                         burst;
    sig_kind_e                  kind;
    logic signed [SAMPLE_W-1:0] l, r;
    while (count > 0) begin
      burst    = $urandom_range(1, 32);
      // full-scale noise gets extra weight
      kind     = ($urandom_range(0, 2) == 0) ? SIG_FULL : sig_kind_e'($urandom_range(0, 5));
      dc_left  = longint'($urandom_range(0, 8_000_000)) - 4_000_000;
      dc_right = longint'($urandom_range(0, 8_000_000)) - 4_000_000;
      while (burst > 0 && count > 0) begin
        make_pair(kind, l, r);
        offer(l, r);
        burst--;
        count--;
      end
      // idle gaps of random length land on every step of the schedule
      if (gaps && $urandom_range(0, 3) != 0)
        pause($urandom_range(1, 24));
    end
  endtask

  // main stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: rails, zero, alternating bit patterns
    offer(PAIR_MAX, PAIR_MAX);
    offer(PAIR_MIN, PAIR_MIN);
    offer(PAIR_MAX, PAIR_MIN);
    offer(PAIR_MIN, PAIR_MAX);
    offer(0, 0);
    offer(24'h555555, 24'hAAAAAA);
    offer(24'hAAAAAA, 24'h555555);
    offer(1, -1);
    settle();

    // zero pole: the whole signal goes through the low band
    set_config('0, WIDTH_RST, NORM_RST, WIDTH_RST, NORM_RST);
    offer(PAIR_MAX, PAIR_MIN);
    offer(12345, -54321);
    offer(PAIR_MIN, PAIR_MIN);
    offer(0, PAIR_MAX);
    settle();

    // every register at all ones: large gains push the output into saturation
    set_config('1, '1, '1, '1, '1);
    offer(PAIR_MAX, PAIR_MIN);
    offer(PAIR_MIN, PAIR_MAX);
    offer(1_000_000, -1_000_000);
    offer(PAIR_MAX, PAIR_MAX);
    offer(PAIR_MIN, PAIR_MIN);
    offer(0, 0);
    settle();

    // zero width folds both bands to mono
    set_config(POLE_RST, '0, 16'd32768, '0, 16'd32768);
    offer(PAIR_MAX, PAIR_MIN);
    offer(100, 200);
    settle();

    // slowest pole, double width, zero norm
    set_config('1, 16'd32768, '0, 16'd32768, '0);
    offer(PAIR_MAX, PAIR_MIN);
    offer(PAIR_MIN, PAIR_MAX);

    // random phases, each with its own register set and flow-control style
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      case (ph)
        0:       set_config(POLE_RST, WIDTH_RST, NORM_RST, WIDTH_RST, NORM_RST);
        1:       set_config('1, '1, '1, '1, '1);
        2:       set_config('0, '0, '0, '0, '0);
        default: set_config(pick_pole(), pick_gain(WIDTH_RST), pick_gain(NORM_RST),
                            pick_gain(WIDTH_RST), pick_gain(NORM_RST));
      endcase
      // first phase runs flat out on both sides
      rx_mode       = (ph == 0) ? RX_ALWAYS : rx_mode_e'($urandom_range(0, 2));
      stall_pattern = 16'($urandom) | 16'h0001;
      if (ph == 1 || ph == 4)
        hold_off = 1'b1;
      run_phase(PHASE_ITEMS, ph != 0);
    end
    settle();

    if (enhancer_model.pending() != 0)
      $display("%0d results never arrived", enhancer_model.pending());
    if (enhancer_model.failed())
      $display("two_band_stereo_width_enhancer test failed");
    else
      $display("two_band_stereo_width_enhancer test passed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("two_band_stereo_width_enhancer test failed");
    $finish;
  end

endmodule
